FILE: hw/rtl/pid_controller_with_feedforward_top_assert.svh
// Assertion macros for the PID controller checker.
// Needs clk and rst_n in scope where the macros are used.
`ifndef PID_CONTROLLER_WITH_FEEDFORWARD_TOP_ASSERT_SVH
`define PID_CONTROLLER_WITH_FEEDFORWARD_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PIDFF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PIDFF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// checked across reset
`define PIDFF_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/pidff_pkg.sv
// Shared widths and register indexes for the PID controller.
// No dependencies.
package pidff_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int GAIN_W         = 16;
  localparam int LIMIT_W        = 32;
  localparam int DRIVE_W        = 32;
  localparam int SUM_W          = 40;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = 3;

  localparam int ERR_W  = SAMPLE_W + 1;
  localparam int DERR_W = SAMPLE_W + 2;
  localparam int PFF_W  = GAIN_W + SAMPLE_W;
  localparam int PP_W   = GAIN_W + ERR_W;
  localparam int PI_W   = GAIN_W + SUM_W;
  localparam int PD_W   = GAIN_W + DERR_W;
  localparam int ACC_W  = PI_W + 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_GAIN_P  = 3'd0;
  localparam cfg_idx_t CFG_GAIN_I  = 3'd1;
  localparam cfg_idx_t CFG_GAIN_D  = 3'd2;
  localparam cfg_idx_t CFG_GAIN_FF = 3'd3;
  localparam cfg_idx_t CFG_OUT_MIN = 3'd4;
  localparam cfg_idx_t CFG_OUT_MAX = 3'd5;
  localparam cfg_idx_t CFG_TARGET  = 3'd6;

  localparam logic action_clear = 1'b1;

endpackage

FILE: hw/rtl/pid_controller_with_feedforward_top.sv
// PID controller with setpoint feedforward and output clamp, top level.
// Depends on pidff_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per sample:
//   in_action = 0 updates with in_measured_value, in_action = 1 clears the
//   integral and the previous error and produces no result.
//   Result channel (out_valid / out_stall) returns out_drive_value, one per
//   update, in order.
//   Three register stages: error and integral, four gain products, then sum,
//   floor shift and clamp. A result passes s1, s2 and the output register in order;
//   one transaction per cycle is taken while the output keeps draining.
//   A stall on the result side backs up the stages; in_stall rises only when
//   every stage is full.
//   Integral and previous error are updated when a transaction is accepted.
//   cfg_wr_en writes register cfg_index with cfg_wdata at once; the user
//   writes only while no transaction is in flight (not enforced). Unknown
//   indexes are ignored. Synchronous reset clears the pipeline, integral and
//   registers to defaults (gains and target 0, clamp at full 32-bit range).
module pid_controller_with_feedforward_top
  import pidff_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic signed [SAMPLE_W-1:0] in_measured_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DRIVE_W-1:0]  out_drive_value,
  input  logic                       cfg_wr_en,
  input  cfg_idx_t                   cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  logic signed [GAIN_W-1:0]   gain_p_r, gain_i_r, gain_d_r, gain_ff_r;
  logic signed [LIMIT_W-1:0]  out_min_r, out_max_r;
  logic signed [SAMPLE_W-1:0] target_r;

  logic signed [SUM_W-1:0] error_sum_r, sum_nxt;
  logic signed [ERR_W-1:0] prev_err_r, err_nxt;
  logic signed [SUM_W:0]   sum_ext;
  logic signed [DERR_W-1:0] derr_nxt;

  logic                     s1_valid_r;
  logic signed [ERR_W-1:0]  s1_err_r;
  logic signed [DERR_W-1:0] s1_derr_r;
  logic signed [SUM_W-1:0]  s1_sum_r;

  logic                     s2_valid_r;
  logic signed [PFF_W-1:0]  s2_pff_r, pff_nxt;
  logic signed [PP_W-1:0]   s2_pp_r, pp_nxt;
  logic signed [PI_W-1:0]   s2_pi_r, pi_nxt;
  logic signed [PD_W-1:0]   s2_pd_r, pd_nxt;

  logic                     out_valid_r;
  logic signed [DRIVE_W-1:0] drive_r, drive_nxt;

  logic signed [ACC_W-1:0] acc, acc_sh, lim_hi, lim_lo, clip_hi;

  logic out_ok, s2_ok, s1_ok, in_acc;

  // flow control
  assign out_ok   = !out_valid_r || !out_stall;
  assign s2_ok    = !s2_valid_r || out_ok;
  assign s1_ok    = !s1_valid_r || s2_ok;
  assign in_acc   = in_valid && s1_ok;
  assign in_stall = !s1_ok;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r  <= '0;
      gain_i_r  <= '0;
      gain_d_r  <= '0;
      gain_ff_r <= '0;
      out_min_r <= {1'b1, {(LIMIT_W-1){1'b0}}};
      out_max_r <= {1'b0, {(LIMIT_W-1){1'b1}}};
      target_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GAIN_P:  gain_p_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_I:  gain_i_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_D:  gain_d_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_FF: gain_ff_r <= cfg_wdata[GAIN_W-1:0];
        CFG_OUT_MIN: out_min_r <= cfg_wdata[LIMIT_W-1:0];
        CFG_OUT_MAX: out_max_r <= cfg_wdata[LIMIT_W-1:0];
        CFG_TARGET:  target_r  <= cfg_wdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: error, saturating integral, error difference
  always_comb begin
    err_nxt  = ERR_W'(target_r) - ERR_W'(in_measured_value);
    sum_ext  = (SUM_W+1)'(error_sum_r) + (SUM_W+1)'(err_nxt);
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_nxt = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_nxt = sum_ext[SUM_W-1:0];
    end
    derr_nxt = DERR_W'(err_nxt) - DERR_W'(prev_err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= '0;
      prev_err_r  <= '0;
    end else if (in_acc) begin
      if (in_action == action_clear) begin
        error_sum_r <= '0;
        prev_err_r  <= '0;
      end else begin
        error_sum_r <= sum_nxt;
        prev_err_r  <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ok) begin
      s1_valid_r <= in_acc && (in_action != action_clear);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ok) begin
      s1_err_r  <= err_nxt;
      s1_derr_r <= derr_nxt;
      s1_sum_r  <= sum_nxt;
    end
  end

  // stage 2: gain products
  always_comb begin
    pff_nxt = gain_ff_r * target_r;
    pp_nxt  = gain_p_r * s1_err_r;
    pi_nxt  = gain_i_r * s1_sum_r;
    pd_nxt  = gain_d_r * s1_derr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ok) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ok) begin
      s2_pff_r <= pff_nxt;
      s2_pp_r  <= pp_nxt;
      s2_pi_r  <= pi_nxt;
      s2_pd_r  <= pd_nxt;
    end
  end

  // stage 3: sum, floor shift, clamp (upper first, then lower)
  always_comb begin
    acc       = ACC_W'(s2_pff_r) + ACC_W'(s2_pp_r) + ACC_W'(s2_pi_r) + ACC_W'(s2_pd_r);
    acc_sh    = acc >>> GAIN_FRAC_BITS;
    lim_hi    = ACC_W'(out_max_r);
    lim_lo    = ACC_W'(out_min_r);
    clip_hi   = (acc_sh > lim_hi) ? lim_hi : acc_sh;
    drive_nxt = (clip_hi < lim_lo) ? out_min_r : clip_hi[DRIVE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ok) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ok) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_value = drive_r;

endmodule

FILE: hw/rtl/pidff_chk.sv
// Port-level checker for the PID controller, bound to the top level.
// Depends on pidff_pkg and pid_controller_with_feedforward_top_assert.svh.
`include "pid_controller_with_feedforward_top_assert.svh"

module pidff_chk
  import pidff_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [DRIVE_W-1:0] out_drive_value,
  input logic                      cfg_wr_en,
  input cfg_idx_t                  cfg_index,
  input logic [CFG_DATA_W-1:0]     cfg_wdata
);

  logic signed [LIMIT_W-1:0] min_r, max_r;
  logic                      out_held;
  logic                      clamp_ok;

  // shadow copy of the clamp limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= {1'b1, {(LIMIT_W-1){1'b0}}};
      max_r <= {1'b0, {(LIMIT_W-1){1'b1}}};
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_OUT_MIN) begin
        min_r <= cfg_wdata[LIMIT_W-1:0];
      end
      if (cfg_index == CFG_OUT_MAX) begin
        max_r <= cfg_wdata[LIMIT_W-1:0];
      end
    end
  end

  assign out_held = out_valid && out_stall;
  assign clamp_ok = (min_r > max_r) ? (out_drive_value == min_r) :
                    ((out_drive_value >= min_r) && (out_drive_value <= max_r));

  `PIDFF_ASSERT_RST(a_rst_empty, !out_valid, "result valid straight after reset")
  `PIDFF_ASSERT_NXT(a_valid_hold, out_held, out_valid, "stalled result dropped")
  `PIDFF_ASSERT_NXT(a_data_hold, out_held, $stable(out_drive_value), "stalled result changed")
  `PIDFF_ASSERT(a_clamp, out_valid, clamp_ok, "drive value outside clamp limits")

endmodule

bind pid_controller_with_feedforward_top pidff_chk u_pidff_chk (.*);
